FILE: hdl/percent_url_decoder_top_defines.svh
// Assertion helpers for the percent decoder.
// Both sample on clk and are switched off while rst_n is low.
`ifndef PERCENT_URL_DECODER_TOP_DEFINES_SVH
`define PERCENT_URL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define PUD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pud_pkg.sv
package pud_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Decoder phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,   // plain byte expected
        PH_PCT  = 3'b010,   // '%' seen
        PH_HIGH = 3'b100    // '%' and first digit seen
    } pud_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pud_item_t;

    // Hex-ish digit value: 0-9, letters 10..35, anything else 0.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h5A)
            begin
                v = c - 8'h41 + 8'd10;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                v = c - 8'h61 + 8'd10;
            end
            digit_value = v[5:0];
        end
    endfunction

    // '+' maps to space, everything else passes.
    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        begin
            plain_byte = (c == CH_PLUS) ? CH_SPACE : c;
        end
    endfunction

endpackage

FILE: hdl/percent_url_decoder_top.sv
// A decoded byte is registered in the output queue and shows on m_tdata once the
// entries ahead of it are taken. One input byte per cycle while s_tready is high; an
// unfinished '%' escape followed by the string end gives two output bytes, which can stall input.
// Output side is a three-entry register queue; s_tready is high while it holds at most one.
// Reset (rst_n low, asynchronous): queue emptied, phase back to plain byte.
`include "percent_url_decoder_top_defines.svh"

module percent_url_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    localparam int QDEPTH = 3;

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    pud_pkg::pud_phase_t phase_reg, phase_next;
    logic [5:0]          high_reg, high_next;

    // Output queue: entry 0 is the head shown on the master side.
    pud_pkg::pud_item_t q_reg [QDEPTH];
    pud_pkg::pud_item_t q_next [QDEPTH];
    logic [1:0]         cnt_reg, cnt_next;

    logic               acc_in;
    logic               pop;
    logic [1:0]         n_push;
    pud_pkg::pud_item_t push0, push1;
    logic [5:0]         dig;
    logic [7:0]         hex_byte;
    logic [1:0]         base;
    logic [1:0]         base_p1;

    // Room for the worst case of two results per request.
    assign s_tready = (cnt_reg <= 2'd1);
    assign acc_in   = s_tvalid && s_tready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tlast  = q_reg[0].last;
    assign pop      = m_tvalid && m_tready;

    assign dig      = pud_pkg::digit_value(s_tdata);
    // 16*a + b mod 256: only the low nibble of a survives the shift.
    assign hex_byte = {high_reg[3:0], 4'b0000} + {2'b00, dig};

    // ------------------------------------------------------------------
    // Per-byte decode
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        high_next  = high_reg;
        n_push     = 2'd0;
        push0      = '{data: s_tdata, last: s_tlast};
        push1      = '{data: pud_pkg::plain_byte(s_tdata), last: 1'b1};
        case (phase_reg)
            pud_pkg::PH_PCT:
            begin
                if (s_tlast)
                begin
                    // escape cut short: give '%' back, then this byte as plain
                    n_push     = 2'd2;
                    push0      = '{data: pud_pkg::CH_PERCENT, last: 1'b0};
                    phase_next = pud_pkg::PH_IDLE;
                end
                else
                begin
                    high_next  = dig;
                    phase_next = pud_pkg::PH_HIGH;
                end
            end
            pud_pkg::PH_HIGH:
            begin
                n_push     = 2'd1;
                push0      = '{data: hex_byte, last: s_tlast};
                phase_next = pud_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = pud_pkg::PH_IDLE;
                if (s_tdata == pud_pkg::CH_PERCENT)
                begin
                    if (s_tlast)
                    begin
                        n_push = 2'd1;
                        push0  = '{data: pud_pkg::CH_PERCENT, last: 1'b1};
                    end
                    else
                    begin
                        phase_next = pud_pkg::PH_PCT;
                    end
                end
                else
                begin
                    n_push = 2'd1;
                    push0  = '{data: pud_pkg::plain_byte(s_tdata), last: s_tlast};
                end
            end
        endcase
        if (!acc_in)
        begin
            phase_next = phase_reg;
            high_next  = high_reg;
            n_push     = 2'd0;
        end
    end

    // ------------------------------------------------------------------
    // Queue update: shift out the head, then append behind the survivors
    // ------------------------------------------------------------------
    assign base    = cnt_reg - {1'b0, pop};
    assign base_p1 = base + 2'd1;

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((n_push != 2'd0) && (base == 2'(i)))
            begin
                q_next[i] = push0;
            end
            if ((n_push == 2'd2) && (base_p1 == 2'(i)))
            begin
                q_next[i] = push1;
            end
        end
        cnt_next = base + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pud_pkg::PH_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        high_reg <= high_next;
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PUD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "output request changed while stalled")
    `PUD_ASSERT_NEXT(a_pct_enter,
        acc_in && (phase_reg == pud_pkg::PH_IDLE) && (s_tdata == pud_pkg::CH_PERCENT) && !s_tlast,
        (phase_reg == pud_pkg::PH_PCT) && ($past(cnt_reg) != 2'd0 || !m_tvalid),
        "open escape did not enter percent phase or produced output")
    `PUD_ASSERT_NEXT(a_cut_two, acc_in && (phase_reg == pud_pkg::PH_PCT) && s_tlast,
        m_tvalid && (cnt_reg >= 2'd2) && (phase_reg == pud_pkg::PH_IDLE),
        "cut-short escape did not queue two bytes")

endmodule
